>>> hdl/csem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csem_pkg
// Types, codes and sizes shared by the counting semaphore wait queue.
// ----------------------------------------------------------------------------
package csem_pkg;

    localparam int MAX_THREADS     = 16;
    localparam int PRIORITY_LEVELS = 8;

    localparam int ID_W    = 4;
    localparam int PRIO_W  = 3;
    localparam int COUNT_W = 9;
    localparam int INIT_W  = 8;

    localparam logic signed [COUNT_W-1:0] COUNT_TOP = 9'sd255;

    // operation codes
    localparam logic [1:0] MODE_WAIT       = 2'd0;
    localparam logic [1:0] MODE_SIGNAL     = 2'd1;
    localparam logic [1:0] MODE_SIGNAL_ALL = 2'd2;
    localparam logic [1:0] MODE_QUERY      = 2'd3;

    // result status codes
    localparam logic [2:0] STAT_GRANTED   = 3'd0;
    localparam logic [2:0] STAT_BLOCKED   = 3'd1;
    localparam logic [2:0] STAT_WOKE      = 3'd2;
    localparam logic [2:0] STAT_NONE      = 3'd3;
    localparam logic [2:0] STAT_FOUND     = 3'd4;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd5;
    localparam logic [2:0] STAT_FULL      = 3'd6;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ID_W-1:0]   thread_id;
        logic [PRIO_W-1:0] priority_req;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [ID_W-1:0]   woken_id;
        logic [PRIO_W-1:0] woken_priority;
        logic              last;
    } out_item_t;

    // commands broadcast to every cell
    typedef struct packed {
        logic              clear;
        logic              enq;
        logic              pop;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] pri;
    } q_ctrl_t;

    // queue status seen by the controller
    typedef struct packed {
        logic              empty;
        logic              full;
        logic              more;
        logic              found;
        logic [ID_W-1:0]   head_id;
        logic [PRIO_W-1:0] head_pri;
    } q_stat_t;

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } ctl_state_t;

    function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
        logic [PRIO_W:0] wide;
        wide = {1'b0, p};
        if (wide >= (PRIO_W+1)'(PRIORITY_LEVELS))
            return PRIO_W'(PRIORITY_LEVELS - 1);
        return p;
    endfunction

endpackage

>>> hdl/counting_semaphore_wait_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_unit
// Counting semaphore with a first-in first-out queue of blocked threads.
// ----------------------------------------------------------------------------
// Wait, signal and query: the result is formed in the cycle the item is
// accepted and held in the output register, and the next item is taken as
// soon as that register is free or being emptied. Signal-all on a non-empty
// queue releases its waiters one by one after it is accepted, each leaving
// the head of the cell chain with one shift while the output register is
// free; a full queue holds 16 threads. Writing the initial count reloads the
// counter and empties the queue; it is taken only while no signal-all runs,
// and input items are held off in any cycle in which a write is offered.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_unit
    import csem_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [INIT_W-1:0] cfg_data
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    logic signed [COUNT_W-1:0] count_reg;
    logic signed [COUNT_W-1:0] count_next;
    logic signed [COUNT_W-1:0] count_inc;

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    q_ctrl_t ctrl;
    q_stat_t stat;

    logic slot_free;
    logic in_fire;
    logic cfg_fire;
    logic drain_go;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_fire   = in_valid && !in_stall;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign count_inc = (count_reg < COUNT_TOP) ? count_reg + 9'sd1 : count_reg;

    csem_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .key   (in_item.thread_id),
        .stat  (stat)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && in_item.mode == MODE_SIGNAL_ALL && !stat.empty)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (slot_free && !stat.more)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall  = 1'b1;
        cfg_ready = 1'b0;
        drain_go  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                // an offered write goes ahead of any item
                in_stall  = !slot_free || cfg_valid;
                cfg_ready = 1'b1;
            end
            S_DRAIN:
            begin
                drain_go = slot_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // datapath: counter, queue commands, result
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        ctrl.clear     = 1'b0;
        ctrl.enq       = 1'b0;
        ctrl.pop       = 1'b0;
        ctrl.id        = in_item.thread_id;
        ctrl.pri       = clamp_prio(in_item.priority_req);

        if (cfg_fire)
        begin
            ctrl.clear = 1'b1;
            count_next = COUNT_W'({1'b0, cfg_data});
        end
        else if (drain_go)
        begin
            count_next     = count_inc;
            ctrl.pop       = 1'b1;
            out_valid_next = 1'b1;
            out_item_next  = '{status: STAT_WOKE, woken_id: stat.head_id,
                               woken_priority: stat.head_pri, last: !stat.more};
        end
        else if (in_fire)
        begin
            out_valid_next = 1'b1;
            out_item_next  = '{status: STAT_NONE, woken_id: '0,
                               woken_priority: '0, last: 1'b1};
            case (in_item.mode)
                MODE_WAIT:
                begin
                    if (count_reg > 9'sd0)
                    begin
                        count_next           = count_reg - 9'sd1;
                        out_item_next.status = STAT_GRANTED;
                    end
                    else if (stat.full)
                    begin
                        out_item_next.status = STAT_FULL;
                    end
                    else
                    begin
                        count_next           = count_reg - 9'sd1;
                        ctrl.enq             = 1'b1;
                        out_item_next.status = STAT_BLOCKED;
                    end
                end
                MODE_SIGNAL:
                begin
                    count_next = count_inc;
                    if (count_inc <= 9'sd0 && !stat.empty)
                    begin
                        ctrl.pop                     = 1'b1;
                        out_item_next.status         = STAT_WOKE;
                        out_item_next.woken_id       = stat.head_id;
                        out_item_next.woken_priority = stat.head_pri;
                    end
                end
                MODE_SIGNAL_ALL:
                begin
                    // a non-empty queue is drained one waiter per cycle while the output register is free
                    if (!stat.empty)
                        out_valid_next = out_valid_reg && out_stall;
                end
                MODE_QUERY:
                begin
                    out_item_next.status = stat.found ? STAT_FOUND : STAT_NOT_FOUND;
                end
                default:
                begin
                    out_item_next.status = STAT_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> hdl/csem_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csem_cell
// One slot of the wait queue: holds a thread id and priority, fills when it
// is the first free slot, and takes its upper neighbor's entry on a pop; a clear empties it.
// ----------------------------------------------------------------------------
module csem_cell
    import csem_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  q_ctrl_t           ctrl,
    input  logic [ID_W-1:0]   key,
    input  logic              prev_valid,
    input  logic              nbr_valid,
    input  logic [ID_W-1:0]   nbr_id,
    input  logic [PRIO_W-1:0] nbr_pri,
    output logic              valid,
    output logic [ID_W-1:0]   id,
    output logic [PRIO_W-1:0] pri,
    output logic              match
);

    logic              valid_reg;
    logic              valid_next;
    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;
    logic [PRIO_W-1:0] pri_reg;
    logic [PRIO_W-1:0] pri_next;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        pri_next   = pri_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.pop)
        begin
            valid_next = nbr_valid;
            id_next    = nbr_id;
            pri_next   = nbr_pri;
        end
        else if (ctrl.enq && !valid_reg && prev_valid)
        begin
            // first free slot in the chain
            valid_next = 1'b1;
            id_next    = ctrl.id;
            pri_next   = ctrl.pri;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        pri_reg <= pri_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign pri   = pri_reg;
    assign match = valid_reg && (id_reg == key);

endmodule

>>> hdl/csem_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csem_queue
// Row of wait queue cells, head at cell 0, entries shift toward the head on
// every pop.
// ----------------------------------------------------------------------------
module csem_queue
    import csem_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  q_ctrl_t         ctrl,
    input  logic [ID_W-1:0] key,
    output q_stat_t         stat
);

    logic [MAX_THREADS-1:0]   valid;
    logic [MAX_THREADS-1:0]   match;
    logic [ID_W-1:0]          ids  [MAX_THREADS];
    logic [PRIO_W-1:0]        pris [MAX_THREADS];

    for (genvar i = 0; i < MAX_THREADS; i++)
    begin : g_cell
        logic              prev_v;
        logic              nbr_v;
        logic [ID_W-1:0]   nbr_i;
        logic [PRIO_W-1:0] nbr_p;

        if (i == 0)
        begin : g_first
            assign prev_v = 1'b1;
        end
        else
        begin : g_mid
            assign prev_v = valid[i-1];
        end

        if (i == MAX_THREADS - 1)
        begin : g_end
            assign nbr_v = 1'b0;
            assign nbr_i = '0;
            assign nbr_p = '0;
        end
        else
        begin : g_link
            assign nbr_v = valid[i+1];
            assign nbr_i = ids[i+1];
            assign nbr_p = pris[i+1];
        end

        csem_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key        (key),
            .prev_valid (prev_v),
            .nbr_valid  (nbr_v),
            .nbr_id     (nbr_i),
            .nbr_pri    (nbr_p),
            .valid      (valid[i]),
            .id         (ids[i]),
            .pri        (pris[i]),
            .match      (match[i])
        );
    end

    always_comb
    begin
        stat.empty    = !valid[0];
        stat.full     = valid[MAX_THREADS-1];
        stat.more     = valid[1];
        stat.found    = |match;
        stat.head_id  = ids[0];
        stat.head_pri = pris[0];
    end

endmodule

>>> hdl/csem_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csem_check
// Port-level checks for the counting semaphore wait queue.
// ----------------------------------------------------------------------------
module csem_check
    import csem_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input out_item_t         out_item,
    input logic              cfg_ready
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // only wake-ups of a signal-all come in runs
    a_run_woke: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.last |-> out_item.status == STAT_WOKE)
        else $error("non-final result that is not a wake-up");

    // no new item or write while a signal-all run is still going
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.last |-> in_stall && !cfg_ready)
        else $error("item or write taken during a signal-all run");

    // status code stays in range
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.status != 3'd7)
        else $error("undefined status code");

    // woken fields are zero unless a thread was released
    a_woken_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != STAT_WOKE
        |-> out_item.woken_id == '0 && out_item.woken_priority == '0)
        else $error("woken fields set without a wake-up");

endmodule

bind counting_semaphore_wait_queue_unit csem_check u_csem_check (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the counting semaphore with its wait queue. A
// scoreboard tracks count and waiter order, predicts every reply for each
// accepted item and checks the replies in order while both sides stall.
// ----------------------------------------------------------------------------
module tb;
    import csem_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 70;
    localparam int NUM_PHASES  = 6;

    class sem_scoreboard;
        logic signed [COUNT_W-1:0] sem_count;
        logic [ID_W-1:0]           wq_id  [MAX_THREADS];
        logic [PRIO_W-1:0]         wq_pri [MAX_THREADS];
        logic [ID_W-1:0]           rd_ptr;
        logic [ID_W-1:0]           wr_ptr;
        logic [ID_W:0]             depth;
        out_item_t                 replies_q [$];
        int unsigned               fault_count;

        function new();
            sem_count   = '0;
            rd_ptr      = '0;
            wr_ptr      = '0;
            depth       = '0;
            fault_count = 0;
        endfunction

        function void load_count(input logic [INIT_W-1:0] v);
            sem_count = {1'b0, v};
            rd_ptr    = '0;
            wr_ptr    = '0;
            depth     = '0;
        endfunction

        function void add_reply(input logic [2:0] st, input logic [ID_W-1:0] id,
                                input logic [PRIO_W-1:0] pr, input logic lst);
            out_item_t r;
            r = {st, id, pr, lst};
            replies_q.push_back(r);
        endfunction

        // one unit back to the count; pops the head while count is not positive
        function bit release_one(output logic [ID_W-1:0] id, output logic [PRIO_W-1:0] pr);
            id = '0;
            pr = '0;
            if (sem_count < COUNT_TOP)
                sem_count++;
            if (sem_count <= 0 && depth != 0)
            begin
                id = wq_id[rd_ptr];
                pr = wq_pri[rd_ptr];
                rd_ptr++;
                depth--;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_op(input in_item_t it);
            logic [PRIO_W-1:0] pri;
            logic [ID_W-1:0]   id;
            logic [PRIO_W-1:0] pr;
            logic [ID_W-1:0]   p;
            bit                hit;
            pri = it.priority_req;
            if (pri >= PRIORITY_LEVELS)
                pri = PRIO_W'(PRIORITY_LEVELS - 1);
            case (it.mode)
                MODE_WAIT:
                begin
                    if (sem_count > 0)
                    begin
                        sem_count--;
                        add_reply(STAT_GRANTED, '0, '0, 1'b1);
                    end
                    else if (depth == MAX_THREADS)
                        add_reply(STAT_FULL, '0, '0, 1'b1);
                    else
                    begin
                        sem_count--;
                        wq_id[wr_ptr]  = it.thread_id;
                        wq_pri[wr_ptr] = pri;
                        wr_ptr++;
                        depth++;
                        add_reply(STAT_BLOCKED, '0, '0, 1'b1);
                    end
                end
                MODE_SIGNAL:
                begin
                    if (release_one(id, pr))
                        add_reply(STAT_WOKE, id, pr, 1'b1);
                    else
                        add_reply(STAT_NONE, '0, '0, 1'b1);
                end
                MODE_SIGNAL_ALL:
                begin
                    if (depth == 0)
                        add_reply(STAT_NONE, '0, '0, 1'b1);
                    while (depth != 0)
                    begin
                        // positive count with waiters left: take the head anyway
                        if (!release_one(id, pr))
                        begin
                            id = wq_id[rd_ptr];
                            pr = wq_pri[rd_ptr];
                            rd_ptr++;
                            depth--;
                        end
                        add_reply(STAT_WOKE, id, pr, depth == 0);
                    end
                end
                default:
                begin
                    hit = 1'b0;
                    p   = rd_ptr;
                    for (int i = 0; i < depth; i++)
                    begin
                        if (wq_id[p] == it.thread_id)
                            hit = 1'b1;
                        p++;
                    end
                    add_reply(hit ? STAT_FOUND : STAT_NOT_FOUND, '0, '0, 1'b1);
                end
            endcase
        endfunction

        function void report(input string what, input out_item_t want, input out_item_t got);
            fault_count++;
            if (fault_count <= 10)
                $display("%0t %s: exp status=%0d id=%0d pri=%0d last=%0d, got status=%0d id=%0d pri=%0d last=%0d",
                         $realtime, what, want.status, want.woken_id, want.woken_priority,
                         want.last, got.status, got.woken_id, got.woken_priority, got.last);
        endfunction

        function void check_reply(input out_item_t got);
            out_item_t want;
            if (replies_q.size() == 0)
            begin
                report("unexpected reply", '0, got);
                return;
            end
            want = replies_q.pop_front();
            if (got.status !== want.status || got.woken_id !== want.woken_id ||
                got.woken_priority !== want.woken_priority || got.last !== want.last)
                report("reply mismatch", want, got);
        endfunction

        function int unsigned pending();
            return replies_q.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    in_item_t          in_item;
    logic              out_valid;
    logic              out_stall;
    out_item_t         out_item;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [INIT_W-1:0] cfg_data;

    sem_scoreboard sb;
    int            send_idle_pct;
    int            recv_idle_pct;
    int unsigned   cycles;

    counting_semaphore_wait_queue_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // replies are taken at the next rising edge, so check them ahead of it
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_reply(out_item);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_item(input in_item_t it);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        sb.note_op(it);
    endtask

    task automatic push_op(input logic [1:0] mode, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] pri);
        in_item_t it;
        it = {mode, id, pri};
        push_item(it);
    endtask

    // hold the sender until every reply is back
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_init_count(input logic [INIT_W-1:0] v);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        sb.load_count(v);
    endtask

    // flavor 0 fills the queue, 1 drains it, 2 is uniform
    function automatic in_item_t gen_item(input int flavor);
        in_item_t it;
        int       r;
        r = $urandom_range(0, 99);
        if (flavor == 0)
            it.mode = (r < 70) ? MODE_WAIT : (r < 85) ? MODE_QUERY :
                      (r < 95) ? MODE_SIGNAL : MODE_SIGNAL_ALL;
        else if (flavor == 1)
            it.mode = (r < 15) ? MODE_WAIT : (r < 55) ? MODE_SIGNAL :
                      (r < 80) ? MODE_QUERY : MODE_SIGNAL_ALL;
        else
            it.mode = 2'($urandom_range(0, 3));
        // a narrow id range makes query hits common
        if ($urandom_range(0, 1))
            it.thread_id = ID_W'($urandom_range(0, 3));
        else
            it.thread_id = ID_W'($urandom_range(0, 15));
        it.priority_req = PRIO_W'($urandom_range(0, 7));
        return it;
    endfunction

    initial
    begin
        logic [INIT_W-1:0] phase_count [NUM_PHASES];
        int                flavor;
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        out_stall     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        cycles        = 0;
        send_idle_pct = 10;
        recv_idle_pct = 75;
        flavor        = 0;
        sb = new();
        phase_count[0] = 8'd255;
        phase_count[1] = 8'd0;
        phase_count[2] = INIT_W'($urandom_range(0, 3));
        phase_count[3] = 8'd0;
        phase_count[4] = INIT_W'($urandom_range(0, 255));
        phase_count[5] = 8'd1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_init_count(8'd0);
        push_op(MODE_WAIT, 4'd0, 3'd0);
        push_op(MODE_WAIT, 4'd15, 3'd7);
        push_op(MODE_QUERY, 4'd15, 3'd0);
        push_op(MODE_QUERY, 4'd3, 3'd7);
        push_op(MODE_SIGNAL, 4'd0, 3'd0);
        push_op(MODE_SIGNAL_ALL, 4'd0, 3'd0);
        // signal-all with nobody waiting
        push_op(MODE_SIGNAL_ALL, 4'd15, 3'd7);
        for (int i = 0; i < MAX_THREADS; i++)
            push_op(MODE_WAIT, ID_W'(i), PRIO_W'(i));
        // wait on a full queue
        push_op(MODE_WAIT, 4'd9, 3'd5);
        push_op(MODE_SIGNAL_ALL, 4'd0, 3'd0);
        settle();

        // saturation at the top of the count
        write_init_count(8'd255);
        push_op(MODE_SIGNAL, 4'd0, 3'd0);
        push_op(MODE_WAIT, 4'd1, 3'd1);
        push_op(MODE_SIGNAL, 4'd0, 3'd0);
        settle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph < 2)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 75;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_init_count(phase_count[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 16 == 0)
                    flavor = $urandom_range(0, 2);
                push_item(gen_item(flavor));
                if (n == PHASE_ITEMS / 2)
                    settle();
            end
            settle();
        end

        repeat (40) @(posedge clk);
        if (sb.fault_count == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
hdl/csem_pkg.sv
hdl/csem_cell.sv
hdl/csem_queue.sv
hdl/counting_semaphore_wait_queue_unit.sv
hdl/csem_check.sv
tb/tb.sv
